@@ rtl/core/cwmlc_pkg.sv @@
package cwmlc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CH_W     = 6;
    localparam int CAP_W    = 24;
    localparam int LEVEL_W  = 3;
    localparam int TALLY_W  = 7;
    localparam int SUM_W    = 40;
    localparam int SCALE_W  = 32;
    localparam int BOUND_W  = 21;
    localparam int NUM_LEVELS = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
    localparam logic [CAP_W-1:0]   CAP_MAX   = '1;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLOSE  = 1'b1
    } t_cmd;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SCALE   = 3'd0,
        REG_BOUND_0 = 3'd1,
        REG_BOUND_1 = 3'd2,
        REG_BOUND_2 = 3'd3,
        REG_BOUND_3 = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                       command;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]    channel_out;
        logic [CAP_W-1:0]   cap_value;
        logic [LEVEL_W-1:0] level;
        logic [TALLY_W-1:0] count_level0;
        logic [TALLY_W-1:0] count_level1;
        logic [TALLY_W-1:0] count_level2;
        logic [TALLY_W-1:0] count_level3;
        logic [TALLY_W-1:0] count_level4;
        logic               last;
    } t_out_item;

endpackage

@@ rtl/core/channel_window_mean_level_classifier_unit.sv @@
// channel  direction  handshake           payload
// in       input      i_valid / o_stall   t_in_item  (command, channel, sample_value)
// out      output     o_valid / i_stall   t_out_item (one beat per channel on close)
// cfg      input      i_cfg_we            i_cfg_index, i_cfg_data
// a sample beat reads memory, then adds and writes back
// a close beat walks every channel: read, 40-step restoring divide, one multiply,
// then the result beat
// after reset a clearing pass zeroes the memory; no beat is taken during it;
// output stalls hold the walk in the emit step
module channel_window_mean_level_classifier_unit
    import cwmlc_pkg::*;
#(
    parameter int CHANNELS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  t_in_item        i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_item       o_data,
    input  logic            i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data
);

    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CW  = $clog2(CHANNELS + 1);
    localparam int MW  = SUM_W + COUNT_BITS;
    localparam int DCW = $clog2(SUM_W + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0]      SUM_MAX   = '1;
    localparam logic [CW-1:0]         LAST_CH   = CW'(CHANNELS - 1);

    logic [MW-1:0] mem [CHANNELS];
    logic [MW-1:0] r_rd;
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [MW-1:0] mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= mem[mem_raddr];
    end

    logic [SCALE_W-1:0]        r_scale;
    logic signed [BOUND_W-1:0] r_bound [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= SCALE_W'(65536);
            r_bound[0] <= BOUND_W'(5000);
            r_bound[1] <= BOUND_W'(10000);
            r_bound[2] <= BOUND_W'(15000);
            r_bound[3] <= BOUND_W'(20000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCALE:   r_scale    <= i_cfg_data;
                REG_BOUND_0: r_bound[0] <= i_cfg_data[BOUND_W-1:0];
                REG_BOUND_1: r_bound[1] <= i_cfg_data[BOUND_W-1:0];
                REG_BOUND_2: r_bound[2] <= i_cfg_data[BOUND_W-1:0];
                REG_BOUND_3: r_bound[3] <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_ch, n_ch;
    logic [SAMPLE_W-1:0] r_val, n_val;
    logic [SUM_W-1:0] r_quo, n_quo;
    logic [COUNT_BITS:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_den, n_den;
    logic [DCW-1:0] r_step, n_step;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic [TALLY_W-1:0] r_tally [NUM_LEVELS];
    logic [TALLY_W-1:0] n_tally [NUM_LEVELS];
    logic r_ovalid, n_ovalid;
    t_out_item r_odata, n_odata;

    logic [SUM_W-1:0] rd_sum;
    logic [COUNT_BITS-1:0] rd_cnt;
    assign rd_sum = r_rd[MW-1:COUNT_BITS];
    assign rd_cnt = r_rd[COUNT_BITS-1:0];

    logic [CAP_W+SCALE_W-1:0] prod;
    logic [CAP_W+SCALE_W-17:0] prod_sh;
    logic [COUNT_BITS:0] rem_sh;
    logic signed [CAP_W+1:0] cap_s;
    logic [LEVEL_W-1:0] lv;

    // mean never exceeds the largest sample, so the low 24 quotient bits hold it
    assign prod    = {{SCALE_W{1'b0}}, r_quo[CAP_W-1:0]} * {{CAP_W{1'b0}}, r_scale};
    assign prod_sh = prod[CAP_W+SCALE_W-1:16];
    assign rem_sh  = {r_rem[COUNT_BITS-1:0], r_quo[SUM_W-1]};
    assign cap_s   = {2'b00, r_cap};

    always_comb begin
        priority if (cap_s < (CAP_W+2)'(signed'(r_bound[0]))) lv = 3'd0;
        else if (cap_s < (CAP_W+2)'(signed'(r_bound[1])))  lv = 3'd1;
        else if (cap_s < (CAP_W+2)'(signed'(r_bound[2])))  lv = 3'd2;
        else if (cap_s <= (CAP_W+2)'(signed'(r_bound[3]))) lv = 3'd3;
        else lv = 3'd4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++) r_tally[k] <= '0;
        end else begin
            r_state  <= n_state;
            r_ch     <= n_ch;
            r_ovalid <= n_ovalid;
            for (int k = 0; k < NUM_LEVELS; k++) r_tally[k] <= n_tally[k];
        end
        r_val   <= n_val;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_step  <= n_step;
        r_cap   <= n_cap;
        r_odata <= n_odata;
    end

    always_comb begin
        n_state  = r_state;
        n_ch     = r_ch;
        n_val    = r_val;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_den    = r_den;
        n_step   = r_step;
        n_cap    = r_cap;
        n_tally  = r_tally;
        n_ovalid = r_ovalid && i_stall;
        n_odata  = r_odata;
        o_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = r_ch[AW-1:0];
        mem_wdata = '0;
        mem_raddr = r_ch[AW-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_ch   = r_ch + 1'b1;
                if (r_ch == LAST_CH) begin
                    n_ch    = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_stall   = 1'b0;
                mem_raddr = i_data.channel[AW-1:0];
                if (i_valid) begin
                    if (i_data.command == CMD_CLOSE) begin
                        n_ch    = '0;
                        for (int k = 0; k < NUM_LEVELS; k++) n_tally[k] = '0;
                        n_state = ST_READ;
                    end else if (i_data.sample_value > 0 &&
                                 {3'b000, i_data.channel} < (CH_W+3)'(CHANNELS)) begin
                        n_ch    = CW'(i_data.channel);
                        n_val   = i_data.sample_value;
                        n_state = ST_ADD;
                    end
                end
            end
            ST_ADD: begin
                mem_wdata = {rd_sum + SUM_W'(r_val), rd_cnt + 1'b1};
                mem_we = (rd_cnt != COUNT_MAX) && (rd_sum <= SUM_MAX - SUM_W'(r_val));
                n_state = ST_IDLE;
            end
            ST_READ: begin
                // read data valid next cycle; the DIV setup step captures it
                n_state = ST_DIV;
                n_step  = '0;
            end
            ST_DIV: begin
                if (r_step == '0) begin
                    n_quo  = rd_sum;
                    n_den  = rd_cnt;
                    n_rem  = '0;
                    mem_we = 1'b1;
                    n_step = r_step + 1'b1;
                    if (rd_cnt == '0) begin
                        n_quo   = '0;
                        n_state = ST_MUL;
                    end
                end else begin
                    if (rem_sh >= {1'b0, r_den}) begin
                        n_rem = rem_sh - {1'b0, r_den};
                        n_quo = {r_quo[SUM_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh;
                        n_quo = {r_quo[SUM_W-2:0], 1'b0};
                    end
                    n_step = r_step + 1'b1;
                    if (r_step == DCW'(SUM_W)) n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_cap   = (prod_sh > (CAP_W+SCALE_W-16)'(CAP_MAX)) ? CAP_MAX
                          : prod_sh[CAP_W-1:0];
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_ovalid || !i_stall) begin
                    if (r_tally[lv] != TALLY_MAX) n_tally[lv] = r_tally[lv] + 1'b1;
                    n_ovalid = 1'b1;
                    n_odata.channel_out  = CH_W'(r_ch);
                    n_odata.cap_value    = r_cap;
                    n_odata.level        = lv;
                    n_odata.count_level0 = n_tally[0];
                    n_odata.count_level1 = n_tally[1];
                    n_odata.count_level2 = n_tally[2];
                    n_odata.count_level3 = n_tally[3];
                    n_odata.count_level4 = n_tally[4];
                    n_odata.last         = (r_ch == LAST_CH);
                    n_ch = r_ch + 1'b1;
                    if (r_ch == LAST_CH) begin
                        n_ch    = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

`ifndef SYNTH
    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && n_ovalid && !r_ovalid && n_odata.last) |=>
        (r_state == ST_IDLE)) else $error("walk did not end on last beat");
    a_no_take_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall) else $error("input taken during walk");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");
`endif

endmodule
